// ===== rtl/fke_pkg.sv =====
// Package for the flow key extractor: protocol codes, hash constant, shared types.
// No dependencies.
`default_nettype none
package fke_pkg;
  localparam int FRAG_TABLE_DEPTH_DEF = 512;
  localparam int MAX_VLAN_TAGS_DEF = 8;
  localparam logic [31:0] GOLDEN_MUL = 32'h9e370001;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [7:0] PROTO_SCTP = 8'd132;
  localparam logic REG_NOT_LOCAL = 1'b0;
  localparam logic REG_OVERHEAD = 1'b1;

  // Entry that travels along the cell chain.
  typedef struct packed {
    logic        valid;
    logic [31:0] fp;
    logic [15:0] sport;
    logic [15:0] dport;
  } entry_t;

  // Search result: the hit flag and the ports of the matching entry.
  typedef struct packed {
    logic        hit;
    logic [15:0] sport;
    logic [15:0] dport;
  } probe_t;
endpackage
`default_nettype wire

// ===== rtl/fke_cell.sv =====
// One cell of the fragment table ring: holds one entry and hands it to its neighbor.
// Depends on fke_pkg.
`default_nettype none
module fke_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire logic            load,
  input  wire fke_pkg::entry_t load_entry,
  input  wire fke_pkg::entry_t entry_in,
  output fke_pkg::entry_t      entry
);
  // Reset clears only the valid bit; the rest of the entry means nothing until a load.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (load) begin
      entry <= load_entry;
    end else if (shift) begin
      entry <= entry_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/flow_key_extract_with_frag_table.sv =====
// Top level of the flow key extractor; depends on fke_pkg and fke_cell.
// Holds the cell ring, the hash stage, the control sequencer and the output register.
//
// Each packet is hashed first; then the table, a ring of cells, rotates once per
// packet, so every entry passes the compare point exactly once. The next packet
// is taken only once the result has been transferred out. Slot i of the table is
// the cell at ring position i when the ring is at rest; round-robin replacement
// writes the slot chosen by next_slot after the rotation. No clearing pass is
// needed: the valid bits in the cells clear at reset.
`default_nettype none
module flow_key_extract_with_frag_table #(
  parameter int FRAG_TABLE_DEPTH = fke_pkg::FRAG_TABLE_DEPTH_DEF,
  parameter int MAX_VLAN_TAGS = fke_pkg::MAX_VLAN_TAGS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] eth_type,
  input  wire logic [3:0]  vlan_tags,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [31:0] src_ip,
  input  wire logic [31:0] dst_ip,
  input  wire logic [15:0] ip_ident,
  input  wire logic [15:0] frag_field,
  input  wire logic [31:0] l4_head,
  input  wire logic [7:0]  tcp_flag_bits,
  input  wire logic [15:0] src_domain,
  input  wire logic [15:0] dst_domain,
  input  wire logic [15:0] packet_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic             direction,
  output logic [31:0]      local_addr,
  output logic [31:0]      remote_addr,
  output logic [15:0]      local_port_out,
  output logic [15:0]      remote_port_out,
  output logic [15:0]      local_domain_out,
  output logic [15:0]      remote_domain_out,
  output logic [7:0]       protocol_out,
  output logic [7:0]       flags_out,
  output logic [31:0]      missed_fragments,
  output logic [31:0]      missed_bytes
);
  localparam int SW = $clog2(FRAG_TABLE_DEPTH);
  localparam int CW = $clog2(FRAG_TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [CW-1:0] cnt;
  logic [SW-1:0] next_slot;
  logic [15:0] not_local_domain;
  logic [7:0] frame_overhead;
  logic [31:0] missed_frag_count, missed_byte_count;

  // Captured item.
  logic [15:0] r_etype, r_ident, r_frag, r_sdom, r_ddom, r_plen;
  logic [3:0] r_tags;
  logic [7:0] r_proto, r_tflags;
  logic [31:0] r_sip, r_dip, r_l4;
  logic [31:0] h_s, h_d, h_p, h_i, fp;
  fke_pkg::probe_t hit_r;

  // Configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      not_local_domain <= 16'hffff;
      frame_overhead <= 8'd24;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fke_pkg::REG_NOT_LOCAL: not_local_domain <= cfg_data;
        fke_pkg::REG_OVERHEAD:  frame_overhead <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  wire take = in_valid && !in_stall;

  // Cell ring.
  fke_pkg::entry_t ent [FRAG_TABLE_DEPTH];
  fke_pkg::entry_t new_entry;
  logic do_write;
  wire shift = (state == S_SCAN);

  assign new_entry.valid = 1'b1;
  assign new_entry.fp = fp;
  assign new_entry.sport = r_l4[31:16];
  assign new_entry.dport = r_l4[15:0];

  genvar g;
  generate
    for (g = 0; g < FRAG_TABLE_DEPTH; g++) begin : g_cell
      fke_cell u_cell (
        .clk(clk), .rst(rst), .shift(shift),
        .load(do_write && next_slot == SW'(g)),
        .load_entry(new_entry),
        .entry_in(ent[(g + 1) % FRAG_TABLE_DEPTH]),
        .entry(ent[g])
      );
    end
  endgenerate

  wire [12:0] offset = r_frag[12:0];
  wire more = r_frag[13];
  wire l3_ok = (r_tags < 4'(MAX_VLAN_TAGS)) && (r_etype == fke_pkg::ETYPE_IPV4);
  wire is_udp = l3_ok && r_proto == fke_pkg::PROTO_UDP;

  always_comb begin
    do_write = (state == S_DONE) && is_udp && offset == 13'd0 && more && !hit_r.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      next_slot <= '0;
      missed_frag_count <= '0;
      missed_byte_count <= '0;
      cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (take) state <= S_HASH;
        S_HASH: begin
          state <= S_SCAN;
          cnt <= '0;
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(FRAG_TABLE_DEPTH - 1)) state <= S_TAIL;
        end
        S_TAIL: state <= S_DONE;
        S_DONE: begin
          state <= S_OUT;
          out_valid <= 1'b1;
          if (do_write)
            next_slot <= (next_slot == SW'(FRAG_TABLE_DEPTH - 1)) ? '0 : next_slot + 1'b1;
          if (is_udp && offset != 13'd0 && !hit_r.hit) begin
            missed_frag_count <= missed_frag_count + 32'd1;
            missed_byte_count <= missed_byte_count + 32'(r_plen) + 32'(frame_overhead);
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the item, hash partial products, then the head of the ring is compared as the ring turns.
  // The first hit keeps its ports, so the lowest matching slot wins.
  always_ff @(posedge clk) begin
    if (take) begin
      r_etype <= eth_type; r_tags <= vlan_tags; r_proto <= ip_protocol;
      r_sip <= src_ip; r_dip <= dst_ip; r_ident <= ip_ident; r_frag <= frag_field;
      r_l4 <= l4_head; r_tflags <= tcp_flag_bits; r_sdom <= src_domain;
      r_ddom <= dst_domain; r_plen <= packet_length;
    end
    if (state == S_HASH) begin
      h_s <= r_sip * fke_pkg::GOLDEN_MUL;
      h_d <= r_dip * fke_pkg::GOLDEN_MUL;
      h_p <= 32'(r_proto) * fke_pkg::GOLDEN_MUL;
      h_i <= 32'(r_ident) * fke_pkg::GOLDEN_MUL;
    end
    if (state == S_HASH) begin
      hit_r <= '0;
    end else if (state == S_SCAN && !hit_r.hit && ent[0].valid && ent[0].fp == fp) begin
      hit_r.hit <= 1'b1;
      hit_r.sport <= ent[0].sport;
      hit_r.dport <= ent[0].dport;
    end
  end

  assign fp = h_s ^ h_d ^ {h_p[31:16], 16'h0000} ^ {16'h0000, h_i[31:16]};

  // Result.
  logic ok, dir, pok;
  logic [15:0] sp, dp;
  logic [7:0] fl;
  always_comb begin
    pok = 1'b1; sp = r_l4[31:16]; dp = r_l4[15:0]; fl = 8'd0;
    if (!l3_ok) begin
      pok = 1'b0;
    end else begin
      unique case (r_proto)
        fke_pkg::PROTO_TCP: begin
          pok = (offset == 13'd0);
          fl = r_tflags;
        end
        fke_pkg::PROTO_UDP: begin
          if (offset != 13'd0) begin
            pok = hit_r.hit; sp = hit_r.sport; dp = hit_r.dport;
          end
        end
        fke_pkg::PROTO_SCTP: pok = (offset == 13'd0);
        fke_pkg::PROTO_ICMP: begin
          sp = 16'd0; dp = r_l4[31:16];
        end
        default: pok = 1'b0;
      endcase
    end
    ok = pok; dir = 1'b0;
    if (r_sdom < r_ddom) dir = 1'b0;
    else if (r_sdom > r_ddom) dir = 1'b1;
    else if (r_sdom == not_local_domain) ok = 1'b0;
    else dir = !(r_sip < r_dip);
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      accepted <= ok;
      direction <= ok & dir;
      local_addr <= !ok ? '0 : (dir ? r_dip : r_sip);
      remote_addr <= !ok ? '0 : (dir ? r_sip : r_dip);
      local_port_out <= !ok ? '0 : (dir ? dp : sp);
      remote_port_out <= !ok ? '0 : (dir ? sp : dp);
      local_domain_out <= !ok ? '0 : (dir ? r_ddom : r_sdom);
      remote_domain_out <= !ok ? '0 : (dir ? r_sdom : r_ddom);
      protocol_out <= ok ? r_proto : 8'd0;
      flags_out <= ok ? fl : 8'd0;
    end
  end
  assign missed_fragments = missed_frag_count;
  assign missed_bytes = missed_byte_count;
endmodule
`default_nettype wire
